>>> sv/bdq_pkg.sv
package bdq_pkg;

   localparam int unsigned ActionW   = 3;
   localparam int unsigned ItemW     = 32;
   localparam int unsigned PositionW = 5;
   localparam int unsigned FillW     = 6;

   typedef enum logic [ActionW-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_READ_AT    = 3'd4,
      ACT_CLEAR      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

>>> sv/bdq_if.sv
interface bdq_req_if
   import bdq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ActionW-1:0]   action;
   logic [ItemW-1:0]     item;
   logic [PositionW-1:0] position;

   modport source (output valid, output action, output item, output position, input ready);
   modport sink   (input valid, input action, input item, input position, output ready);
endinterface

interface bdq_rsp_if
   import bdq_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ItemW-1:0] item_out;
   logic             ok;
   logic [FillW-1:0] fill_count;

   modport source (output valid, output item_out, output ok, output fill_count, input ready);
   modport sink   (input valid, input item_out, input ok, input fill_count, output ready);
endinterface

>>> sv/bounded_double_ended_queue.sv
// Double-ended queue of handle words over a store of 2*CAPACITY slots. The live run starts
// at the centre; pushes at the back grow it downward, pushes at the front grow it upward,
// and each fails once its own edge of the store is reached even if the other side has room.
// Each request gives exactly one response (item, ok, fill count). After it is accepted the
// request is registered, the EXEC state updates the pointers and accesses the single-port
// slot memory, whose read data is registered, and the RESP state holds the response. A new
// request is taken in the cycle the response is taken; none is taken while one is
// executing. The slot memory needs no clearing after reset; only slots inside the live run
// are ever read.
module bounded_double_ended_queue
   import bdq_pkg::*;
#(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ITEM_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   bdq_req_if.sink  req_ch,
   bdq_rsp_if.source rsp_ch
);

   dp_cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   bdq_dp #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req_ch.action),
      .req_item       (req_ch.item),
      .req_position   (req_ch.position),
      .rsp_item_out   (rsp_ch.item_out),
      .rsp_ok         (rsp_ch.ok),
      .rsp_fill_count (rsp_ch.fill_count)
   );

   a_accept_executes: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> cmd.execute)
      else $error("accepted request not executed next cycle");

   a_execute_responds: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_ch.valid && !cmd.execute))
      else $error("execute not followed by a response");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !req_ch.ready)
      else $error("request taken while executing");

   a_fail_zero_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ok) |-> (rsp_ch.item_out == '0))
      else $error("failed response carries an item");

endmodule

>>> sv/bdq_ctrl.sv
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = req_valid ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            // next request may enter as the response leaves
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

endmodule

>>> sv/bdq_dp.sv
module bdq_dp
   import bdq_pkg::*;
#(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ITEM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [ActionW-1:0]   req_action,
   input  logic [ItemW-1:0]     req_item,
   input  logic [PositionW-1:0] req_position,
   output logic [ItemW-1:0]     rsp_item_out,
   output logic                 rsp_ok,
   output logic [FillW-1:0]     rsp_fill_count
);

   localparam int unsigned Slots = 2 * CAPACITY;
   localparam int unsigned PW    = $clog2(Slots + 1);
   localparam int unsigned AW    = (Slots > 1) ? $clog2(Slots) : 1;
   localparam int unsigned SW    = (ITEM_WIDTH < ItemW) ? ITEM_WIDTH : ItemW;
   localparam int unsigned RW    = ((PW > PositionW) ? PW : PositionW) + 1;

   localparam logic [PW-1:0] Centre   = PW'(CAPACITY);
   localparam logic [PW-1:0] SlotsVal = PW'(Slots);

   logic [SW-1:0] slot_mem [Slots];

   logic [ActionW-1:0]   act_ff;
   logic [SW-1:0]        item_ff;
   logic [PositionW-1:0] pos_ff;

   logic [PW-1:0] back_ff, head_ff, count_ff;
   logic [PW-1:0] back_in, head_in, count_in;
   logic          ok_ff, ok_in;
   logic          sel_ff, sel_in;
   logic [SW-1:0] rd_data_ff;

   logic          wr_en, rd_en;
   logic [AW-1:0] addr;
   logic [PW-1:0] eb, eh;
   logic [RW-1:0] read_idx;
   logic          read_ok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         item_ff <= SW'(req_item);
         pos_ff  <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_ff  <= Centre;
         head_ff  <= Centre;
         count_ff <= '0;
      end else if (cmd.execute) begin
         back_ff  <= back_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         ok_ff  <= ok_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[addr] <= item_ff;
      if (rd_en) rd_data_ff <= slot_mem[addr];
   end

   // an empty run snaps both ends back to the centre
   assign eb       = (count_ff == '0) ? Centre : back_ff;
   assign eh       = (count_ff == '0) ? Centre : head_ff;
   assign read_idx = RW'(back_ff) + RW'(pos_ff);
   assign read_ok  = (RW'(pos_ff) < RW'(count_ff)) && (read_idx < RW'(Slots));

   always_comb begin
      back_in  = back_ff;
      head_in  = head_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      sel_in   = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      addr     = '0;
      unique case (action_type'(act_ff))
         ACT_PUSH_BACK: begin
            back_in = eb;
            head_in = eh;
            addr    = AW'(eb - PW'(1));
            if (eb != '0) begin
               back_in  = eb - PW'(1);
               count_in = count_ff + PW'(1);
               ok_in    = 1'b1;
               wr_en    = cmd.execute;
            end
         end
         ACT_PUSH_FRONT: begin
            back_in = eb;
            head_in = eh;
            addr    = AW'(eh);
            if (eh < SlotsVal) begin
               head_in  = eh + PW'(1);
               count_in = count_ff + PW'(1);
               ok_in    = 1'b1;
               wr_en    = cmd.execute;
            end
         end
         ACT_POP_BACK: begin
            back_in = eb;
            head_in = eh;
            addr    = AW'(eb);
            if (count_ff != '0 && eb < SlotsVal) begin
               back_in  = eb + PW'(1);
               count_in = count_ff - PW'(1);
               ok_in    = 1'b1;
               sel_in   = 1'b1;
               rd_en    = cmd.execute;
            end
         end
         ACT_POP_FRONT: begin
            back_in = eb;
            head_in = eh;
            addr    = AW'(eh - PW'(1));
            if (count_ff != '0 && eh != '0) begin
               head_in  = eh - PW'(1);
               count_in = count_ff - PW'(1);
               ok_in    = 1'b1;
               sel_in   = 1'b1;
               rd_en    = cmd.execute;
            end
         end
         ACT_READ_AT: begin
            addr = AW'(read_idx);
            if (read_ok) begin
               ok_in  = 1'b1;
               sel_in = 1'b1;
               rd_en  = cmd.execute;
            end
         end
         ACT_CLEAR: begin
            back_in  = Centre;
            head_in  = Centre;
            count_in = '0;
            ok_in    = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign rsp_item_out   = sel_ff ? ItemW'(rd_data_ff) : '0;
   assign rsp_ok         = ok_ff;
   assign rsp_fill_count = FillW'(count_ff);

endmodule

>>> tb/deque_response_checker.sv
`timescale 1ns / 1ps

module deque_response_checker
   import bdq_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   bdq_req_if          req_ch,
   bdq_rsp_if          rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned awaited_count,
   output int unsigned checked_count,
   output int unsigned success_count,
   output int unsigned full_side_count,
   output int unsigned peak_fill
);

   localparam int unsigned Slots     = 2 * CAPACITY;
   localparam int unsigned AddrW     = $clog2(Slots);
   localparam int unsigned PendDepth = 8;
   localparam int unsigned PendW     = 3;

   typedef struct packed {
      logic [ItemW-1:0] item_out;
      logic             ok;
      logic [FillW-1:0] fill_count;
   } deque_outcome_type;

   logic [ItemW-1:0]  slot_mem [Slots];
   logic [FillW-1:0]  back_ptr;
   logic [FillW-1:0]  head_ptr;
   logic [FillW-1:0]  live_count;
   deque_outcome_type pending_mem [PendDepth];
   logic [PendW-1:0]  pend_wr_ptr;
   logic [PendW-1:0]  pend_rd_ptr;
   int unsigned       pend_count;

   function automatic void recentre_when_empty();
      if (live_count == 0) begin
         back_ptr = FillW'(CAPACITY);
         head_ptr = FillW'(CAPACITY);
      end
   endfunction

   // applies one request to the shadow deque and returns the response it should give
   function automatic deque_outcome_type deque_apply(input logic [ActionW-1:0]   act,
                                                    input logic [ItemW-1:0]     word,
                                                    input logic [PositionW-1:0] pos);
      deque_outcome_type res = '0;
      int unsigned       idx;
      case (act)
         ACT_PUSH_BACK: begin
            recentre_when_empty();
            if (back_ptr > 0) begin
               back_ptr = back_ptr - 1'b1;
               slot_mem[AddrW'(back_ptr)] = word;
               live_count = live_count + 1'b1;
               res.ok = 1'b1;
            end
         end
         ACT_PUSH_FRONT: begin
            recentre_when_empty();
            if (head_ptr < Slots) begin
               slot_mem[AddrW'(head_ptr)] = word;
               head_ptr = head_ptr + 1'b1;
               live_count = live_count + 1'b1;
               res.ok = 1'b1;
            end
         end
         ACT_POP_BACK: begin
            recentre_when_empty();
            if (live_count > 0 && back_ptr < Slots) begin
               res.item_out = slot_mem[AddrW'(back_ptr)];
               back_ptr = back_ptr + 1'b1;
               live_count = live_count - 1'b1;
               res.ok = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            recentre_when_empty();
            if (live_count > 0 && head_ptr > 0) begin
               head_ptr = head_ptr - 1'b1;
               res.item_out = slot_mem[AddrW'(head_ptr)];
               live_count = live_count - 1'b1;
               res.ok = 1'b1;
            end
         end
         ACT_READ_AT: begin
            idx = int'(back_ptr) + int'(pos);
            if (pos < live_count && idx < Slots) begin
               res.item_out = slot_mem[AddrW'(idx)];
               res.ok = 1'b1;
            end
         end
         ACT_CLEAR: begin
            live_count = '0;
            back_ptr = FillW'(CAPACITY);
            head_ptr = FillW'(CAPACITY);
            res.ok = 1'b1;
         end
         default: ;
      endcase
      res.fill_count = live_count;
      return res;
   endfunction

   always @(posedge clock) begin
      deque_outcome_type want;
      deque_outcome_type got;
      if (reset) begin
         back_ptr = FillW'(CAPACITY);
         head_ptr = FillW'(CAPACITY);
         live_count = '0;
         pend_wr_ptr = '0;
         pend_rd_ptr = '0;
         pend_count = 0;
         awaited_count = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            want = deque_apply(req_ch.action, req_ch.item, req_ch.position);
            if (pend_count == PendDepth) begin
               mismatch_count++;
               $error("more than %0d requests awaiting a response", PendDepth);
            end else begin
               pending_mem[pend_wr_ptr] = want;
               pend_wr_ptr = pend_wr_ptr + 1'b1;
               pend_count++;
            end
            if ((req_ch.action == ACT_PUSH_BACK || req_ch.action == ACT_PUSH_FRONT) && !want.ok)
               full_side_count++;
            if (live_count > peak_fill)
               peak_fill = live_count;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.item_out, rsp_ch.ok, rsp_ch.fill_count};
            checked_count++;
            if (pend_count == 0) begin
               mismatch_count++;
               $error("response with no request waiting: item_out %h ok %b fill_count %0d",
                      got.item_out, got.ok, got.fill_count);
            end else begin
               want = pending_mem[pend_rd_ptr];
               pend_rd_ptr = pend_rd_ptr + 1'b1;
               pend_count--;
               if (want.ok)
                  success_count++;
               if (got.item_out !== want.item_out) begin
                  mismatch_count++;
                  $error("item_out mismatch: expected %h, actual %h", want.item_out, got.item_out);
               end
               if (got.ok !== want.ok) begin
                  mismatch_count++;
                  $error("ok mismatch: expected %b, actual %b", want.ok, got.ok);
               end
               if (got.fill_count !== want.fill_count) begin
                  mismatch_count++;
                  $error("fill_count mismatch: expected %0d, actual %0d",
                         want.fill_count, got.fill_count);
               end
            end
         end
         awaited_count = pend_count;
      end
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bdq_pkg::*;

   localparam int unsigned Capacity       = 16;
   localparam int unsigned RandomRequests = 1500;
   localparam int unsigned CycleLimit     = 200000;

   // codes the block must answer with a plain refusal
   localparam logic [ActionW-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ActionW-1:0] ACT_SPARE_7 = 3'd7;

   typedef enum int unsigned {
      MIX_GROW_BACK,
      MIX_GROW_FRONT,
      MIX_DRAIN,
      MIX_DRIFT_UP,
      MIX_DRIFT_DOWN
   } traffic_mix_type;

   logic        clock;
   logic        reset;
   bit          idle_on;
   int unsigned cycle_count;
   int unsigned sent_count;
   int unsigned mismatch_count;
   int unsigned awaited_count;
   int unsigned checked_count;
   int unsigned success_count;
   int unsigned full_side_count;
   int unsigned peak_fill;

   bdq_req_if req_ch ();
   bdq_rsp_if rsp_ch ();

   bounded_double_ended_queue #(
      .CAPACITY   (Capacity),
      .ITEM_WIDTH (ItemW)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deque_response_checker #(
      .CAPACITY (Capacity)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .awaited_count   (awaited_count),
      .checked_count   (checked_count),
      .success_count   (success_count),
      .full_side_count (full_side_count),
      .peak_fill       (peak_fill)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 13);
   end

   task automatic send_request(input logic [ActionW-1:0]   act,
                               input logic [ItemW-1:0]     word,
                               input logic [PositionW-1:0] pos);
      while (idle_on && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.item     <= word;
      req_ch.position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent_count++;
   endtask

   function automatic logic [ItemW-1:0] random_word();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)
         return '0;
      if (r < 20)
         return '1;
      return ItemW'($urandom);
   endfunction

   function automatic logic [ActionW-1:0] pick_action(input traffic_mix_type mix);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 2)
         return ACT_CLEAR;
      if (r < 3)
         return $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
      r = $urandom_range(99);
      case (mix)
         MIX_GROW_BACK: begin
            if (r < 55) return ACT_PUSH_BACK;
            if (r < 70) return ACT_PUSH_FRONT;
            if (r < 82) return ACT_READ_AT;
            if (r < 91) return ACT_POP_FRONT;
            return ACT_POP_BACK;
         end
         MIX_GROW_FRONT: begin
            if (r < 55) return ACT_PUSH_FRONT;
            if (r < 70) return ACT_PUSH_BACK;
            if (r < 82) return ACT_READ_AT;
            if (r < 91) return ACT_POP_BACK;
            return ACT_POP_FRONT;
         end
         MIX_DRAIN: begin
            if (r < 35) return ACT_POP_BACK;
            if (r < 70) return ACT_POP_FRONT;
            if (r < 88) return ACT_READ_AT;
            if (r < 94) return ACT_PUSH_BACK;
            return ACT_PUSH_FRONT;
         end
         // run slides upward until the front edge of the store stops it
         MIX_DRIFT_UP: begin
            if (r < 45) return ACT_PUSH_FRONT;
            if (r < 85) return ACT_POP_BACK;
            if (r < 95) return ACT_READ_AT;
            return ACT_PUSH_BACK;
         end
         default: begin
            if (r < 45) return ACT_PUSH_BACK;
            if (r < 85) return ACT_POP_FRONT;
            if (r < 95) return ACT_READ_AT;
            return ACT_PUSH_FRONT;
         end
      endcase
   endfunction

   initial begin
      wait (cycle_count >= CycleLimit);
      $error("no progress after %0d cycles, %0d responses still awaited",
             cycle_count, awaited_count);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      traffic_mix_type        mix;
      int unsigned            mix_left;
      logic [ActionW-1:0]     act;
      logic [PositionW-1:0]   pos;

      idle_on         = 1'b1;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_CLEAR;
      req_ch.item     = '0;
      req_ch.position = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pops and an empty read
      send_request(ACT_POP_BACK, random_word(), '0);
      send_request(ACT_POP_FRONT, random_word(), '0);
      send_request(ACT_READ_AT, '1, '0);
      // fill the back half, the last push finds its side exhausted
      send_request(ACT_PUSH_BACK, '1, '1);
      for (int k = 0; k < Capacity; k++)
         send_request(ACT_PUSH_BACK, random_word(), '0);
      send_request(ACT_READ_AT, '0, PositionW'(Capacity));
      send_request(ACT_READ_AT, '0, PositionW'(Capacity - 1));
      send_request(ACT_READ_AT, '0, '1);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_PUSH_FRONT, '0, '1);
      send_request(ACT_SPARE_6, '1, '1);
      send_request(ACT_SPARE_7, '1, '1);
      send_request(ACT_CLEAR, '0, '0);
      send_request(ACT_READ_AT, '0, '0);
      send_request(ACT_POP_FRONT, '0, '0);

      mix_left = 0;
      for (int i = 0; i < RandomRequests; i++) begin
         if (mix_left == 0) begin
            mix      = traffic_mix_type'($urandom_range(4));
            mix_left = $urandom_range(20, 60);
         end
         mix_left--;
         idle_on <= (i < 500 || i >= 800);
         act = pick_action(mix);
         if (act == ACT_READ_AT && $urandom_range(99) < 60)
            pos = PositionW'($urandom_range(15));
         else
            pos = PositionW'($urandom_range(31));
         send_request(act, random_word(), pos);
      end
      req_ch.valid <= 1'b0;

      wait (awaited_count == 0);
      repeat (10) @(posedge clock);

      $display("covered %0d requests over growth at both ends, drift and draining:",
               sent_count);
      $display("%0d responses checked, %0d succeeded", checked_count, success_count);
      $display("%0d pushes refused at an exhausted side, deepest fill %0d of %0d slots",
               full_side_count, peak_fill, 2 * Capacity);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> bounded_double_ended_queue.f
sv/bdq_pkg.sv
sv/bdq_if.sv
sv/bdq_ctrl.sv
sv/bdq_dp.sv
sv/bounded_double_ended_queue.sv
tb/deque_response_checker.sv
tb/testbench.sv
